/* design/epl_pkg.sv */
// ----------------------------------------------------------------------------
// epl_pkg
// Shared constants, the action codes and the carrier sine table for the
// early-prompt-late correlator.
// ----------------------------------------------------------------------------
package epl_pkg;

  // Code and phase format.
  localparam int CODE_LENGTH     = 1023;
  localparam int PHASE_FRAC_BITS = 21;
  localparam int PH_W            = 32;
  localparam int CODE_DEPTH      = CODE_LENGTH + 2;
  localparam int CHIP_IDX_W      = 11;

  // Chip index after rounding: PH_W+1 bit phase, integer part only.
  localparam int IDX_W           = PH_W + 1 - PHASE_FRAC_BITS;

  // The code store is split into an even and an odd bank so that the
  // early and late chips, which always sit at neighboring indices, are
  // read in the same cycle.
  localparam int BANK_DEPTH      = (CODE_DEPTH + 1) / 2;
  localparam int BANK_AW         = $clog2(BANK_DEPTH);

  localparam logic [PH_W:0] LIMIT       = (PH_W + 1)'(CODE_LENGTH) << PHASE_FRAC_BITS;
  localparam logic [PH_W:0] HALF_CHIP   = (PH_W + 1)'(1) << (PHASE_FRAC_BITS - 1);
  localparam logic [PH_W:0] CHIP_M1     = ((PH_W + 1)'(1) << PHASE_FRAC_BITS) - 1'b1;

  // Carrier mixing.
  localparam int LUT_BITS  = 8;
  localparam int LUT_SIZE  = 1 << LUT_BITS;
  localparam int SMP_W     = 8;
  localparam int TRIG_W    = 8;
  localparam int PROD_W    = SMP_W + TRIG_W;

  // Accumulation.
  localparam int ACC_WIDTH = 48;
  localparam int OUT_SUM_W = 48;
  localparam int CNT_W     = 32;
  localparam int NUM_SUMS  = 6;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_START  = 2'd1,
    ACT_SAMPLE = 2'd2
  } action_t;

  typedef logic signed [TRIG_W-1:0] sine_lut_t [LUT_SIZE];

  // Builds round(127*sin(2*pi*k/LUT_SIZE)) with an integer Q30 Taylor series
  // on the first quarter wave, mirrored to the full cycle. Elaboration only.
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t         tbl;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic [63:0]       v;
    logic signed [63:0] acc;
    int unsigned       q;
    int unsigned       kk;
    for (int k = 0; k < LUT_SIZE; k++) begin
      q  = k & (LUT_SIZE / 2 - 1);
      kk = (q <= LUT_SIZE / 4) ? q : LUT_SIZE / 2 - q;
      x  = (64'd6746518852 * 64'(kk) + 64'(LUT_SIZE / 2)) >> LUT_BITS;
      x2 = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          acc = acc - signed'(term);
        end else begin
          acc = acc + signed'(term);
        end
      end
      if (acc < 0) begin
        acc = '0;
      end
      v = (64'd127 * unsigned'(acc) + (64'd1 << 29)) >> 30;
      tbl[k] = ((k & (LUT_SIZE / 2)) != 0) ? -TRIG_W'(v) : TRIG_W'(v);
    end
    return tbl;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

/* design/epl_in_if.sv */
// ----------------------------------------------------------------------------
// epl_in_if
// Request channel into the correlator: chip loads, starts and samples.
// ----------------------------------------------------------------------------
interface epl_in_if;
  import epl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [CHIP_IDX_W-1:0]         chip_index;
  logic                          chip_bit;
  logic signed [SMP_W-1:0]       sample;
  logic [PH_W-1:0]               start_code_phase;
  logic [PH_W-1:0]               code_advance;
  logic [PH_W-1:0]               start_carrier_phase;
  logic signed [PH_W-1:0]        carrier_step;

  modport source (
    output valid, action, chip_index, chip_bit, sample,
           start_code_phase, code_advance, start_carrier_phase, carrier_step,
    input  ready
  );

  modport sink (
    input  valid, action, chip_index, chip_bit, sample,
           start_code_phase, code_advance, start_carrier_phase, carrier_step,
    output ready
  );
endinterface

/* design/epl_out_if.sv */
// ----------------------------------------------------------------------------
// epl_out_if
// Result channel of the correlator: one request per finished code epoch.
// ----------------------------------------------------------------------------
interface epl_out_if;
  import epl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [OUT_SUM_W-1:0]   early_i;
  logic signed [OUT_SUM_W-1:0]   early_q;
  logic signed [OUT_SUM_W-1:0]   prompt_i;
  logic signed [OUT_SUM_W-1:0]   prompt_q;
  logic signed [OUT_SUM_W-1:0]   late_i;
  logic signed [OUT_SUM_W-1:0]   late_q;
  logic [CNT_W-1:0]              sample_count;
  logic [PH_W-1:0]               next_code_phase;
  logic [PH_W-1:0]               next_carrier_phase;

  modport source (
    output valid, early_i, early_q, prompt_i, prompt_q, late_i, late_q,
           sample_count, next_code_phase, next_carrier_phase,
    input  ready
  );

  modport sink (
    input  valid, early_i, early_q, prompt_i, prompt_q, late_i, late_q,
           sample_count, next_code_phase, next_carrier_phase,
    output ready
  );
endinterface

/* design/early_prompt_late_correlator.sv */
// ----------------------------------------------------------------------------
// early_prompt_late_correlator
// Spreading-code correlator with early, prompt and late taps, a carrier
// sine/cosine table and six saturating accumulators.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on in_ch. A load request writes one chip of the
// spreading code into the code store. A start request sets the code and
// carrier phases and steps and opens a new integration, dropping any running
// one. Each sample request of an open integration is mixed with the carrier
// and correlated against the early, prompt and late chips. When the code
// phase reaches the end of the code, one result request leaves on out_ch
// with the six sums, the sample count and the wrapped phases, and the
// integration closes. A start whose phase is at or past the end gives a
// result with zero sums.
// Throughput is one request per cycle unless the pipeline holds, set by the
// phase update and by one read of each code bank per cycle. A result moves
// through stage A and stage B into the output register once the request
// that ends the epoch is taken. If the receiver stalls, the output register
// holds its result and requests keep flowing until a second result reaches
// the last stage; then the pipeline and in_ch.ready hold until out_ch.ready
// frees the register. Reset clears the phases, sums, count and the open
// flag and needs no clearing pass. The code store is not cleared at reset.
// ----------------------------------------------------------------------------
module early_prompt_late_correlator (
  input  logic       clk,
  input  logic       rst_n,
  epl_in_if.sink     in_ch,
  epl_out_if.source  out_ch
);
  import epl_pkg::*;

  // --------------------------------------------------------------------------
  // Front state, updated at request acceptance.
  // --------------------------------------------------------------------------
  logic                    active_r, active_nxt;
  logic [PH_W-1:0]         code_phase_r, code_phase_nxt;
  logic [PH_W-1:0]         code_inc_r, code_inc_nxt;
  logic [PH_W-1:0]         car_phase_r, car_phase_nxt;
  logic [PH_W-1:0]         car_inc_r, car_inc_nxt;

  // The pipeline advances as one; it only holds when a finished result
  // reaches the last stage while the output register is occupied and out_ch.ready is low.
  logic                    en;
  logic                    acc;
  logic                    is_load, is_start, is_smp;

  // --------------------------------------------------------------------------
  // Stage A registers: token after acceptance, code bank read data.
  // --------------------------------------------------------------------------
  logic                    a_vld_r;
  logic                    a_start_r;
  logic                    a_emit_r;
  logic [PH_W-1:0]         a_code_r;
  logic [PH_W-1:0]         a_car_r;
  logic signed [TRIG_W-1:0] a_sin_r;
  logic signed [TRIG_W-1:0] a_cos_r;
  logic signed [SMP_W-1:0] a_smp_r;
  logic                    a_epar_r;
  logic                    a_eok_r;
  logic                    a_lok_r;
  logic                    a_plate_r;

  logic                    a_vld_nxt;
  logic                    a_emit_nxt;
  logic [PH_W-1:0]         a_code_nxt;
  logic [PH_W-1:0]         a_car_nxt;

  // --------------------------------------------------------------------------
  // Stage B registers: products and chip signs.
  // --------------------------------------------------------------------------
  logic                    b_vld_r;
  logic                    b_start_r;
  logic                    b_emit_r;
  logic [PH_W-1:0]         b_code_r;
  logic [PH_W-1:0]         b_car_r;
  logic signed [PROD_W-1:0] b_bi_r;
  logic signed [PROD_W-1:0] b_bq_r;
  logic                    b_eneg_r;
  logic                    b_pneg_r;
  logic                    b_lneg_r;

  // --------------------------------------------------------------------------
  // Accumulators and output register.
  // --------------------------------------------------------------------------
  logic signed [ACC_WIDTH-1:0] sums_r   [NUM_SUMS];
  logic signed [ACC_WIDTH-1:0] sums_nxt [NUM_SUMS];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic signed [OUT_SUM_W-1:0] out_sum_r [NUM_SUMS];
  logic [CNT_W-1:0]        out_count_r;
  logic [PH_W-1:0]         out_code_r;
  logic [PH_W-1:0]         out_car_r;

  // --------------------------------------------------------------------------
  // Code store: two single-port-read banks, even and odd chip indices.
  // --------------------------------------------------------------------------
  logic                    mem_even [BANK_DEPTH];
  logic                    mem_odd  [BANK_DEPTH];
  logic                    q_even_r;
  logic                    q_odd_r;

  logic                    wr_ok;
  logic [BANK_AW-1:0]      wr_addr;
  logic [BANK_AW-1:0]      rd_even_addr;
  logic [BANK_AW-1:0]      rd_odd_addr;

  // Index arithmetic for the three taps of the current code phase.
  logic [PH_W:0]           base;
  logic [PH_W:0]           base_early;
  logic [IDX_W-1:0]        idx_early;
  logic [IDX_W-1:0]        idx_prompt;
  logic [IDX_W-1:0]        idx_even;
  logic                    early_ok;
  logic                    late_ok;

  logic [PH_W:0]           start_ext;
  logic [PH_W:0]           adv;
  logic [LUT_BITS-1:0]     sin_idx;
  logic [LUT_BITS-1:0]     cos_idx;

  // Stage A to B combinational terms.
  logic                    bit_early, bit_late;
  logic                    eneg_nxt, lneg_nxt, pneg_nxt;
  logic signed [PROD_W-1:0] bi_nxt, bq_nxt;

  // Last-stage terms.
  logic signed [PROD_W-1:0] delta [NUM_SUMS];
  logic [ACC_WIDTH:0]      wide  [NUM_SUMS];

  assign en        = !(b_vld_r && b_emit_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready = en;
  assign acc       = in_ch.valid && en;
  assign is_load   = acc && (in_ch.action == ACT_LOAD);
  assign is_start  = acc && (in_ch.action == ACT_START);
  assign is_smp    = acc && (in_ch.action == ACT_SAMPLE) && active_r;

  // The early tap is ceil(p - 0.5); the late tap is always the next index,
  // and the prompt tap coincides with one of them.
  assign base       = {1'b0, code_phase_r} + CHIP_M1;
  assign base_early = base - HALF_CHIP;
  assign idx_early  = base_early[PH_W:PHASE_FRAC_BITS];
  assign idx_prompt = base[PH_W:PHASE_FRAC_BITS];
  assign early_ok   = idx_early < IDX_W'(CODE_DEPTH);
  assign late_ok    = idx_early < IDX_W'(CODE_DEPTH - 1);
  assign idx_even   = idx_early + IDX_W'(idx_early[0]);

  assign rd_even_addr = (idx_early[0] ? late_ok : early_ok)
                        ? BANK_AW'(idx_even >> 1) : '0;
  assign rd_odd_addr  = (idx_early[0] ? early_ok : late_ok)
                        ? BANK_AW'(idx_early >> 1) : '0;

  assign wr_ok   = in_ch.chip_index < CHIP_IDX_W'(CODE_DEPTH);
  assign wr_addr = BANK_AW'(in_ch.chip_index >> 1);

  assign sin_idx = car_phase_r[PH_W-1 -: LUT_BITS];
  assign cos_idx = sin_idx + LUT_BITS'(LUT_SIZE / 4);

  assign start_ext = {1'b0, in_ch.start_code_phase};
  assign adv       = {1'b0, code_phase_r} + {1'b0, code_inc_r};

  // Loads are written at their own acceptance edge, so a sample taken in
  // the next cycle already reads the new chip; no forwarding is needed.
  always_ff @(posedge clk) begin
    if (is_load && wr_ok && !in_ch.chip_index[0]) begin
      mem_even[wr_addr] <= in_ch.chip_bit;
    end
    if (is_load && wr_ok && in_ch.chip_index[0]) begin
      mem_odd[wr_addr] <= in_ch.chip_bit;
    end
    if (is_smp) begin
      q_even_r <= mem_even[rd_even_addr];
      q_odd_r  <= mem_odd[rd_odd_addr];
    end
  end

  // Front state and the token that enters the pipeline.
  always_comb begin
    active_nxt     = active_r;
    code_phase_nxt = code_phase_r;
    code_inc_nxt   = code_inc_r;
    car_phase_nxt  = car_phase_r;
    car_inc_nxt    = car_inc_r;
    a_vld_nxt      = 1'b0;
    a_emit_nxt     = 1'b0;
    a_code_nxt     = PH_W'(start_ext - LIMIT);
    a_car_nxt      = in_ch.start_carrier_phase;
    if (is_start) begin
      a_vld_nxt      = 1'b1;
      a_emit_nxt     = start_ext >= LIMIT;
      code_phase_nxt = in_ch.start_code_phase;
      code_inc_nxt   = in_ch.code_advance;
      car_phase_nxt  = in_ch.start_carrier_phase;
      car_inc_nxt    = in_ch.carrier_step;
      active_nxt     = !(start_ext >= LIMIT);
    end else if (is_smp) begin
      a_vld_nxt      = 1'b1;
      a_emit_nxt     = adv >= LIMIT;
      car_phase_nxt  = car_phase_r + car_inc_r;
      a_car_nxt      = car_phase_nxt;
      if (adv >= LIMIT) begin
        code_phase_nxt = PH_W'(adv - LIMIT);
        active_nxt     = 1'b0;
      end else begin
        code_phase_nxt = adv[PH_W-1:0];
      end
      a_code_nxt     = code_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      code_phase_r <= '0;
      code_inc_r   <= '0;
      car_phase_r  <= '0;
      car_inc_r    <= '0;
    end else begin
      active_r     <= active_nxt;
      code_phase_r <= code_phase_nxt;
      code_inc_r   <= code_inc_nxt;
      car_phase_r  <= car_phase_nxt;
      car_inc_r    <= car_inc_nxt;
    end
  end

  // Stage A.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_start_r <= is_start;
      a_emit_r  <= a_emit_nxt;
      a_code_r  <= a_code_nxt;
      a_car_r   <= a_car_nxt;
      a_sin_r   <= SINE_LUT[sin_idx];
      a_cos_r   <= SINE_LUT[cos_idx];
      a_smp_r   <= in_ch.sample;
      a_epar_r  <= idx_early[0];
      a_eok_r   <= early_ok;
      a_lok_r   <= late_ok;
      a_plate_r <= idx_prompt != idx_early;
    end
  end

  // Stage A to B: pick early and late chips from the banks, mix the sample.
  always_comb begin
    bit_early = a_epar_r ? q_odd_r : q_even_r;
    bit_late  = a_epar_r ? q_even_r : q_odd_r;
    eneg_nxt  = a_eok_r && bit_early;
    lneg_nxt  = a_lok_r && bit_late;
    pneg_nxt  = a_plate_r ? lneg_nxt : eneg_nxt;
    bi_nxt    = a_sin_r * a_smp_r;
    bq_nxt    = a_cos_r * a_smp_r;
  end

  // Stage B.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_start_r <= a_start_r;
      b_emit_r  <= a_emit_r;
      b_code_r  <= a_code_r;
      b_car_r   <= a_car_r;
      b_bi_r    <= bi_nxt;
      b_bq_r    <= bq_nxt;
      b_eneg_r  <= eneg_nxt;
      b_pneg_r  <= pneg_nxt;
      b_lneg_r  <= lneg_nxt;
    end
  end

  // Last stage: a start token clears the sums, a sample token adds its six
  // signed terms with saturation at ACC_WIDTH bits.
  always_comb begin
    delta[0] = b_eneg_r ? -b_bi_r : b_bi_r;
    delta[1] = b_eneg_r ? -b_bq_r : b_bq_r;
    delta[2] = b_pneg_r ? -b_bi_r : b_bi_r;
    delta[3] = b_pneg_r ? -b_bq_r : b_bq_r;
    delta[4] = b_lneg_r ? -b_bi_r : b_bi_r;
    delta[5] = b_lneg_r ? -b_bq_r : b_bq_r;
    for (int j = 0; j < NUM_SUMS; j++) begin
      wide[j] = {sums_r[j][ACC_WIDTH-1], sums_r[j]} + (ACC_WIDTH + 1)'(delta[j]);
      sums_nxt[j] = sums_r[j];
      if (b_vld_r) begin
        if (b_start_r) begin
          sums_nxt[j] = '0;
        end else if (wide[j][ACC_WIDTH] != wide[j][ACC_WIDTH-1]) begin
          sums_nxt[j] = wide[j][ACC_WIDTH]
                        ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                        : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
        end else begin
          sums_nxt[j] = wide[j][ACC_WIDTH-1:0];
        end
      end
    end
    count_nxt = count_r;
    if (b_vld_r) begin
      if (b_start_r) begin
        count_nxt = '0;
      end else if (!(&count_r)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_SUMS; j++) begin
        sums_r[j] <= '0;
      end
      count_r <= '0;
    end else if (en) begin
      for (int j = 0; j < NUM_SUMS; j++) begin
        sums_r[j] <= sums_nxt[j];
      end
      count_r <= count_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && b_vld_r && b_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && b_vld_r && b_emit_r) begin
      for (int j = 0; j < NUM_SUMS; j++) begin
        out_sum_r[j] <= OUT_SUM_W'(sums_nxt[j]);
      end
      out_count_r <= count_nxt;
      out_code_r  <= b_code_r;
      out_car_r   <= b_car_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.early_i            = out_sum_r[0];
  assign out_ch.early_q            = out_sum_r[1];
  assign out_ch.prompt_i           = out_sum_r[2];
  assign out_ch.prompt_q           = out_sum_r[3];
  assign out_ch.late_i             = out_sum_r[4];
  assign out_ch.late_q             = out_sum_r[5];
  assign out_ch.sample_count       = out_count_r;
  assign out_ch.next_code_phase    = out_code_r;
  assign out_ch.next_carrier_phase = out_car_r;

`ifndef SYNTHESIS
  // A sample that arrives with no open integration leaves no token.
  a_idle_sample_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.action == ACT_SAMPLE && !active_r) |=> !a_vld_r)
    else $error("sample accepted while idle entered the pipeline");

  // A token that ends the epoch closes the integration.
  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && a_vld_nxt && a_emit_nxt) |=> !active_r)
    else $error("integration still open after its final request");

  // A new result only comes from an ending token in the last stage.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(b_vld_r && b_emit_r))
    else $error("result appeared without an ending token");

  // While the pipeline holds, the last stage keeps its token and sums.
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(b_code_r) && $stable(count_r) && b_vld_r))
    else $error("last stage changed during a hold");
`endif

endmodule
